@@ hdl/rgbws_pkg.sv @@
// Shared types and constants for the RGB 3x3 weighted smoothing filter.
// Holds the kernel weights and the per-channel weighted sum function.
// No dependencies.
package rgbws_pkg;

  localparam int CfgW  = 12;
  localparam int ChanW = 8;
  localparam int PixW  = 3 * ChanW;
  localparam int SumW  = 13;
  localparam int PendW = 13;
  localparam int Taps  = 9;

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  localparam logic [2:0] KernelWeights [Taps] = '{
    3'd1, 3'd2, 3'd1,
    3'd3, 3'd4, 3'd3,
    3'd1, 3'd2, 3'd1
  };

  typedef logic [PixW-1:0] pixel_t;
  typedef logic [Taps-1:0][ChanW-1:0] chan_win_t;

  function automatic logic [SumW-1:0] chan_sum(input chan_win_t s);
    logic [SumW-1:0] acc;
    acc = '0;
    for (int k = 0; k < Taps; k++) begin
      acc = acc + SumW'(KernelWeights[k]) * SumW'(s[k]);
    end
    return acc;
  endfunction

endpackage

@@ hdl/rgb_3x3_weighted_smoothing.sv @@
// RGB 3x3 weighted smoothing filter, top level.
// Uses rgbws_pkg and one rgbws_ram instance holding both previous rows.
//
// Usage:
//   s_axis carries raster-order pixels (tuser low) or flush ticks (tuser high).
//   m_axis carries one weighted 3x3 sum per channel; tlast marks the frame's
//   last output pixel. Border and drained tail results carry zero sums.
//   cfg writes frame_width (index 0) and frame_height (index 1); write only
//   while the block is idle. cfg_ready_o is always high.
// Throughput: one item per clock unless stalled; the pixel path is a line-store
//   read stage followed by the window/adder stage feeding the output register.
// Path: a result reaches m_axis through the read stage and the output
//   register; the first own result of a frame comes with the pixel one row
//   plus one pixel later, and flush ticks drain the remaining width+1 results.
// Reset: frame 640 x 480, window cleared, position at the frame start, no
//   pending tail. Line store contents are undefined until written.
// Stall: with m_axis_tready low, one result is held in the output register
//   and one more item is taken into the read stage; then s_axis_tready drops.
module rgb_3x3_weighted_smoothing #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [rgbws_pkg::CfgW-1:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red_sum[12:0], green_sum[25:13],
                                      // blue_sum[38:26], zero pad[39]
  output logic        m_axis_tlast    // frame_end
);

  import rgbws_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int CMP_W = (COL_W + 1 > CfgW) ? COL_W + 1 : CfgW;
  localparam logic [CfgW-1:0] WidthCap = (MAX_WIDTH > 4095) ? 12'hFFF : CfgW'(MAX_WIDTH);

  logic [CfgW-1:0]  frame_width_q, frame_height_q;
  logic [CfgW-1:0]  eff_w, eff_h;

  logic [COL_W-1:0] col_q, col_d;
  logic [CfgW-1:0]  row_q, row_d;
  logic [PendW-1:0] pend_q, pend_d;

  logic             s_acc;
  logic             s_pixel;
  logic [COL_W-1:0] c_use;
  logic [CfgW-1:0]  r_use;
  logic [COL_W:0]   c_inc;
  logic             emit_d, live_d, last_d;

  logic             a_valid_q, a_pixel_q, a_emit_q, a_live_q, a_last_q;
  logic [COL_W-1:0] a_col_q;
  pixel_t           a_px_q;
  logic             a_adv;

  logic [2*PixW-1:0] rd_data;
  pixel_t           above, above2;

  pixel_t           win_q [Taps];
  pixel_t           win_d [Taps];
  chan_win_t        red_w, green_w, blue_w;

  logic             out_valid_q;
  logic [SumW-1:0]  red_q, green_q, blue_q;
  logic             out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(640);
      frame_height_q <= CfgW'(480);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = frame_width_q;
    if (frame_width_q < CfgW'(3)) begin
      eff_w = CfgW'(3);
    end else if (frame_width_q > WidthCap) begin
      eff_w = WidthCap;
    end
    eff_h = (frame_height_q < CfgW'(3)) ? CfgW'(3) : frame_height_q;
  end

  assign a_adv         = a_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_pixel       = (s_axis_tuser[0] == OpPixel);

  // position, tail count and result flags for the accepted item
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    c_use  = col_q;
    r_use  = row_q;
    c_inc  = '0;
    emit_d = 1'b0;
    live_d = 1'b0;
    last_d = 1'b0;
    if (s_acc) begin
      if (!s_pixel) begin
        if (pend_q != '0) begin
          emit_d = 1'b1;
          last_d = (pend_q == PendW'(1));
          pend_d = pend_q - PendW'(1);
        end
      end else begin
        if (CMP_W'(col_q) >= CMP_W'(eff_w)) begin
          c_use = '0;
          r_use = row_q + CfgW'(1);
        end
        if (r_use >= eff_h) begin
          r_use = '0;
        end
        if (r_use >= CfgW'(2) || (r_use == CfgW'(1) && c_use != '0)) begin
          emit_d = 1'b1;
          live_d = (r_use >= CfgW'(2)) && (c_use >= COL_W'(2));
        end else if (pend_q != '0) begin
          emit_d = 1'b1;
          last_d = (pend_q == PendW'(1));
          pend_d = pend_q - PendW'(1);
        end
        c_inc = {1'b0, c_use} + (COL_W+1)'(1);
        row_d = r_use;
        col_d = c_inc[COL_W-1:0];
        if (CMP_W'(c_inc) >= CMP_W'(eff_w)) begin
          col_d = '0;
          row_d = r_use + CfgW'(1);
          if (row_d >= eff_h) begin
            row_d  = '0;
            pend_d = PendW'(eff_w) + PendW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pend_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      if (s_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_pixel_q <= s_pixel;
      a_emit_q  <= emit_d;
      a_live_q  <= live_d;
      a_last_q  <= last_d;
      a_col_q   <= c_use;
      a_px_q    <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end
  end

  rgbws_ram #(
    .DATA_W (2 * PixW),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (a_adv && a_pixel_q),
    .wr_addr_i (a_col_q),
    .wr_data_i ({a_px_q, above}),
    .rd_en_i   (s_acc && s_pixel),
    .rd_addr_i (c_use),
    .rd_data_o (rd_data)
  );

  assign above  = rd_data[2*PixW-1:PixW];
  assign above2 = rd_data[PixW-1:0];

  always_comb begin
    for (int k = 0; k < Taps; k++) begin
      win_d[k] = win_q[k];
    end
    if (a_adv && a_pixel_q) begin
      for (int k = 0; k < 3; k++) begin
        win_d[k*3]   = win_q[k*3+1];
        win_d[k*3+1] = win_q[k*3+2];
      end
      win_d[2] = above2;
      win_d[5] = above;
      win_d[8] = a_px_q;
    end
    for (int k = 0; k < Taps; k++) begin
      red_w[k]   = win_d[k][23:16];
      green_w[k] = win_d[k][15:8];
      blue_w[k]  = win_d[k][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Taps; k++) begin
        win_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < Taps; k++) begin
        win_q[k] <= win_d[k];
      end
      if (a_adv && a_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_emit_q) begin
      red_q      <= a_live_q ? chan_sum(red_w)   : '0;
      green_q    <= a_live_q ? chan_sum(green_w) : '0;
      blue_q     <= a_live_q ? chan_sum(blue_w)  : '0;
      out_last_q <= a_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, blue_q, green_q, red_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_last_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> red_q == '0 && green_q == '0 && blue_q == '0)
    else $error("frame end result carries nonzero sums");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_adv |=> a_valid_q && $stable(a_col_q) && $stable(rd_data))
    else $error("read stage lost its item or line data while stalled");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(WidthCap) + PendW'(1))
    else $error("tail count exceeds maximum frame width plus one");
`endif

endmodule

@@ hdl/rgbws_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low. No dependencies.
module rgbws_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 2048
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [DATA_W-1:0]                wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [DATA_W-1:0]                rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
